// ===== rtl/gbp_pkg.sv =====
package gbp_pkg;

   localparam int HISTORY_BITS  = 14;
   localparam int IDX_BITS      = 14;
   localparam int TABLE_ENTRIES = 1 << IDX_BITS;
   localparam int COUNTER_WIDTH = 2;
   localparam int ADDR_BITS     = 48;
   localparam int THRESH_BITS   = 2;
   localparam int SEEN_BITS     = 2;
   localparam int HASH_SLICES   = 3;
   localparam int HASH_BITS     = (HISTORY_BITS > IDX_BITS) ? HISTORY_BITS : IDX_BITS;
   localparam int CMP_BITS      = (COUNTER_WIDTH > THRESH_BITS) ? COUNTER_WIDTH : THRESH_BITS;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [THRESH_BITS-1:0]   THRESH_RESET = THRESH_BITS'(1);
   localparam logic [COUNTER_WIDTH-1:0] COUNTER_MAX  = {COUNTER_WIDTH{1'b1}};

   localparam logic MODE_PREDICT = 1'b0;
   localparam logic MODE_UPDATE  = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [ADDR_BITS-1:0] branch_address;
      logic                 outcome_taken;
   } gbp_req_type;

   typedef struct packed {
      logic                 predicted_taken;
      logic [SEEN_BITS-1:0] counter_seen;
   } gbp_rsp_type;

   typedef struct packed {
      logic                mode;
      logic [IDX_BITS-1:0] index;
      logic                outcome_taken;
   } gbp_op_type;

   typedef struct packed {
      logic clearing;
      logic reading;
   } gbp_status_type;

   // history xor three address slices, kept to the table size
   function automatic logic [IDX_BITS-1:0] table_index(
      input logic [ADDR_BITS-1:0]    addr,
      input logic [HISTORY_BITS-1:0] hist
   );
      logic [ADDR_BITS+IDX_BITS-1:0] ext;
      logic [HASH_BITS-1:0]          h;
      ext = {{IDX_BITS{1'b0}}, addr};
      h   = HASH_BITS'(hist);
      for (int k = 0; k < HASH_SLICES; k++) begin
         h = h ^ HASH_BITS'(ext[k*HISTORY_BITS +: IDX_BITS]);
      end
      return h[IDX_BITS-1:0];
   endfunction

endpackage

// ===== rtl/gbp_ram.sv =====
module gbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16384
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gbp_queue.sv =====
module gbp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gbp_pkg::gbp_op_type push_op,
   input  logic                pop,
   output gbp_pkg::gbp_op_type pop_op,
   output logic                not_empty,
   output logic                full
);
   import gbp_pkg::*;

   gbp_op_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] ptr);
      return (ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_BITS'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign pop_op    = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

endmodule

// ===== rtl/gbp_front.sv =====
module gbp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  gbp_pkg::gbp_req_type    req_data,
   input  gbp_pkg::gbp_status_type status,
   input  logic                    q_full,
   output logic                    busy,
   output logic                    push,
   output gbp_pkg::gbp_op_type     push_op
);
   import gbp_pkg::*;

   logic [HISTORY_BITS-1:0] history_ff, history_in;

   assign busy = reset | status.clearing | q_full;
   assign push = start & ~busy;

   // index uses the history before this transaction shifts it
   always_comb begin
      push_op.mode          = req_data.mode;
      push_op.index         = table_index(req_data.branch_address, history_ff);
      push_op.outcome_taken = req_data.outcome_taken;
      history_in            = history_ff;
      if (push && req_data.mode == MODE_UPDATE) begin
         history_in = (history_ff << 1) | HISTORY_BITS'(req_data.outcome_taken);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else begin
         history_ff <= history_in;
      end
   end

endmodule

// ===== rtl/gbp_back.sv =====
module gbp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gbp_pkg::THRESH_BITS-1:0] threshold,
   input  logic                          q_not_empty,
   input  gbp_pkg::gbp_op_type           pop_op,
   output logic                          pop,
   output gbp_pkg::gbp_status_type       status,
   output logic                          rsp_strobe,
   output gbp_pkg::gbp_rsp_type          rsp_data
);
   import gbp_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] clr_idx_ff, clr_idx_in;
   gbp_op_type          op_ff, op_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   gbp_rsp_type         rsp_data_ff, rsp_data_in;

   logic                     ram_wr_en;
   logic [IDX_BITS-1:0]      ram_wr_addr;
   logic [COUNTER_WIDTH-1:0] ram_wr_data;
   logic                     ram_rd_en;
   logic [COUNTER_WIDTH-1:0] ctr;
   logic [COUNTER_WIDTH-1:0] ctr_next;

   gbp_ram #(
      .WIDTH (COUNTER_WIDTH),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pop_op.index),
      .rd_data (ctr)
   );

   // saturating step toward the outcome
   always_comb begin
      ctr_next = ctr;
      if (op_ff.outcome_taken) begin
         if (ctr != COUNTER_MAX) ctr_next = ctr + COUNTER_WIDTH'(1);
      end else begin
         if (ctr != '0) ctr_next = ctr - COUNTER_WIDTH'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      op_in         = op_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      pop           = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = op_ff.index;
      ram_wr_data   = ctr_next;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_ff;
            ram_wr_data = '0;
            clr_idx_in  = clr_idx_ff + IDX_BITS'(1);
            if (clr_idx_ff == {IDX_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_not_empty) begin
               pop       = 1'b1;
               ram_rd_en = 1'b1;
               op_in     = pop_op;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            if (op_ff.mode == MODE_UPDATE) begin
               ram_wr_en = 1'b1;
            end else begin
               rsp_strobe_in               = 1'b1;
               rsp_data_in.predicted_taken = (CMP_BITS'(ctr) >= CMP_BITS'(threshold));
               rsp_data_in.counter_seen    = SEEN_BITS'(ctr);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.reading  = (state_ff == ST_READ);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

// ===== rtl/gshare_branch_predictor.sv =====
// gshare direction predictor: 14-bit global history, 16384 two-bit counters
//
// request channel: drive req_data and raise start; the transaction is taken at
// a rising edge where start is high and busy is low. mode predict returns one
// result, mode update returns none and trains the counter and the history.
// result channel: rsp_strobe is high for exactly one cycle with rsp_data; the
// receiver cannot stall it, so results are never held back.
// csr channel: csr_data carries the taken threshold, written when csr_valid
// and csr_ready are both high; write it only while the block is idle.
//
// result path: with an empty queue a predict result passes the queue entry,
// the back end's table read and the result register; each transaction ahead
// of it first finishes its own table turn. the back end takes a new transaction
// only once the last one's read-then-write loop on the counter table is
// through; a two-entry queue behind the hash stage lets three transactions be
// taken back to back before busy rises. reset: history goes to zero and the
// threshold to 1; then a clearing pass writes zero to every counter, one per
// cycle, during which busy stays high. csr writes are taken throughout.
module gshare_branch_predictor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  gbp_pkg::gbp_req_type            req_data,
   output logic                            rsp_strobe,
   output gbp_pkg::gbp_rsp_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gbp_pkg::THRESH_BITS-1:0] csr_data
);
   import gbp_pkg::*;

   logic [THRESH_BITS-1:0] threshold_ff, threshold_in;
   gbp_status_type         status;
   gbp_op_type             push_op;
   gbp_op_type             pop_op;
   logic                   push;
   logic                   pop;
   logic                   q_full;
   logic                   q_not_empty;

   assign csr_ready    = ~reset;
   assign threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   gbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .status   (status),
      .q_full   (q_full),
      .busy     (busy),
      .push     (push),
      .push_op  (push_op)
   );

   gbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .pop       (pop),
      .pop_op    (pop_op),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   gbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .threshold   (threshold_ff),
      .q_not_empty (q_not_empty),
      .pop_op      (pop_op),
      .pop         (pop),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("transaction pushed into a full queue");

   a_busy_while_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> busy && !rsp_strobe)
      else $error("activity during the table clearing pass");

   a_strobe_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(status.reading))
      else $error("result strobe without a preceding table read");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_not_empty && !status.reading)
      else $error("queue popped while empty or mid transaction");

endmodule
